FILE: rtl/core/table_driven_dfa_engine_unit_defines.svh
// assertion helpers shared by the core modules
`ifndef TABLE_DRIVEN_DFA_ENGINE_UNIT_DEFINES_SVH
`define TABLE_DRIVEN_DFA_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define TDE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tde assertion failed");

// next-cycle implication
`define TDE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tde assertion failed");

`endif

FILE: rtl/core/tde_pkg.sv
package tde_pkg;

  localparam int NUM_STATES      = 64;
  localparam int SYMBOL_BITS     = 8;
  localparam int STATE_BITS      = $clog2(NUM_STATES);
  localparam int TYPE_BITS       = 2;
  localparam int TRANS_DEPTH     = NUM_STATES * (2 ** SYMBOL_BITS);
  localparam int TRANS_ADDR_BITS = STATE_BITS + SYMBOL_BITS;
  localparam int TRANS_WIDTH     = STATE_BITS + 1;

  typedef enum logic [2:0] {
    OP_FEED       = 3'd0,
    OP_ADD_STATE  = 3'd1,
    OP_ADD_TRANS  = 3'd2,
    OP_SET_START  = 3'd3,
    OP_RESET      = 3'd4,
    OP_QUERY      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TYPE  = 2'd1,
    ERR_TRANS = 2'd2,
    ERR_START = 2'd3
  } err_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] symbol;
    logic [5:0] source_state;
    logic [5:0] target_state;
    logic [1:0] type_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [5:0] current_state;
    logic [1:0] state_type;
    logic [1:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic                       clear;
    logic [TRANS_ADDR_BITS-1:0] clr_addr;
    logic                       accept;
    logic                       exec_commit;
    logic                       feed_step;
    logic                       type_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_feed;
  } dp_status_t;

endpackage

FILE: rtl/core/tde_ram.sv
module tde_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tde_ctrl.sv
`include "table_driven_dfa_engine_unit_defines.svh"

module tde_ctrl import tde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_TYPE
  } state_e;

  state_e                     state_q, state_d;
  logic [TRANS_ADDR_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;
  ctrl_cmd_t                  cmd;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    clr_cnt_d        = clr_cnt_q;
    cmd              = '0;
    cmd.clr_addr     = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_feed) begin
          cmd.feed_step = 1'b1;
          state_d       = ST_TYPE;
        end else if (out_free) begin
          cmd.exec_commit = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_TYPE: begin
        if (out_free) begin
          cmd.type_commit = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (cmd.exec_commit || cmd.type_commit) ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `TDE_ASSERT_IMP(a_no_result_in_clear, clk_i, rst_ni, state_q == ST_CLEAR, !out_valid_q)
  `TDE_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd.exec_commit || cmd.type_commit,
                  !out_valid_q || !out_stall_i)
  `TDE_ASSERT_NXT(a_accept_blocks, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

FILE: rtl/core/tde_datapath.sv
`include "table_driven_dfa_engine_unit_defines.svh"

module tde_datapath import tde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  in_item_t   in_item_i,
  output dp_status_t status_o,
  output out_item_t  out_item_o
);

  localparam logic [NUM_STATES-1:0] ValidRst = {{(NUM_STATES-1){1'b0}}, 1'b1};

  in_item_t                   item_q;
  out_item_t                  out_q, out_d;
  logic [STATE_BITS-1:0]      cur_q, cur_d, start_q, start_d;
  logic [TYPE_BITS-1:0]       cur_type_q, cur_type_d, start_type_q, start_type_d;
  logic [NUM_STATES-1:0]      valid_q, valid_d;

  logic                       type_we, type_re;
  logic [STATE_BITS-1:0]      type_waddr, type_raddr;
  logic [TYPE_BITS-1:0]       type_wdata, type_rd;
  logic                       trans_we, trans_re;
  logic [TRANS_ADDR_BITS-1:0] trans_waddr, trans_raddr;
  logic [TRANS_WIDTH-1:0]     trans_wdata, trans_rd;

  logic                       trans_hit;
  logic [STATE_BITS-1:0]      trans_tgt, next_cur, src, dst, in_src;
  logic [SYMBOL_BITS-1:0]     sym, in_sym;
  logic                       src_typed;
  err_e                       err;

  assign src       = item_q.source_state;
  assign dst       = item_q.target_state;
  assign sym       = item_q.symbol[SYMBOL_BITS-1:0];
  assign in_src    = in_item_i.source_state;
  assign in_sym    = in_item_i.symbol[SYMBOL_BITS-1:0];
  assign trans_hit = trans_rd[TRANS_WIDTH-1];
  assign trans_tgt = trans_rd[STATE_BITS-1:0];
  assign next_cur  = trans_hit ? trans_tgt : '0;
  assign src_typed = valid_q[src];

  // reads: at accept the source entries, in a feed the type of the reached state
  assign trans_re    = cmd_i.accept;
  assign trans_raddr = (op_e'(in_item_i.operation) == OP_FEED) ? {cur_q, in_sym}
                                                                : {in_src, in_sym};
  assign type_re     = cmd_i.accept || cmd_i.feed_step;
  assign type_raddr  = cmd_i.accept ? in_src : next_cur;

  always_comb begin
    cur_d        = cur_q;
    cur_type_d   = cur_type_q;
    start_d      = start_q;
    start_type_d = start_type_q;
    valid_d      = valid_q;
    out_d        = out_q;
    err          = ERR_NONE;
    type_we      = cmd_i.clear;
    type_waddr   = cmd_i.clr_addr[STATE_BITS-1:0];
    type_wdata   = '0;
    trans_we     = cmd_i.clear;
    trans_waddr  = cmd_i.clr_addr;
    trans_wdata  = '0;

    if (cmd_i.feed_step) begin
      cur_d = next_cur;
    end

    if (cmd_i.exec_commit) begin
      unique case (op_e'(item_q.operation))
        OP_ADD_STATE: begin
          if (src_typed) begin
            if (type_rd != item_q.type_code) begin
              err = ERR_TYPE;
            end
          end else begin
            type_we      = 1'b1;
            type_waddr   = src;
            type_wdata   = item_q.type_code;
            valid_d[src] = 1'b1;
            if (src == cur_q) begin
              cur_type_d = item_q.type_code;
            end
          end
        end
        OP_ADD_TRANS: begin
          if (trans_hit) begin
            if (trans_tgt != dst) begin
              err = ERR_TRANS;
            end
          end else begin
            trans_we    = 1'b1;
            trans_waddr = {src, sym};
            trans_wdata = {1'b1, dst};
          end
        end
        OP_SET_START: begin
          if (src_typed) begin
            start_d      = src;
            start_type_d = type_rd;
          end else begin
            err = ERR_START;
          end
        end
        OP_RESET: begin
          cur_d      = start_q;
          cur_type_d = start_type_q;
        end
        default: ;
      endcase
      out_d = '{current_state: cur_d, state_type: cur_type_d, error_code: err};
    end

    if (cmd_i.type_commit) begin
      out_d = '{current_state: cur_q, state_type: type_rd, error_code: ERR_NONE};
      if (item_q.last) begin
        cur_d      = start_q;
        cur_type_d = start_type_q;
      end else begin
        cur_type_d = type_rd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      cur_type_q   <= '0;
      start_q      <= '0;
      start_type_q <= '0;
      valid_q      <= ValidRst;
    end else begin
      cur_q        <= cur_d;
      cur_type_q   <= cur_type_d;
      start_q      <= start_d;
      start_type_q <= start_type_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_item_i;
    end
    out_q <= out_d;
  end

  tde_ram #(
    .Width(TYPE_BITS),
    .Depth(NUM_STATES)
  ) u_type_ram (
    .clk_i  (clk_i),
    .we_i   (type_we),
    .waddr_i(type_waddr),
    .wdata_i(type_wdata),
    .re_i   (type_re),
    .raddr_i(type_raddr),
    .rdata_o(type_rd)
  );

  tde_ram #(
    .Width(TRANS_WIDTH),
    .Depth(TRANS_DEPTH)
  ) u_trans_ram (
    .clk_i  (clk_i),
    .we_i   (trans_we),
    .waddr_i(trans_waddr),
    .wdata_i(trans_wdata),
    .re_i   (trans_re),
    .raddr_i(trans_raddr),
    .rdata_o(trans_rd)
  );

  assign status_o.is_feed = (op_e'(item_q.operation) == OP_FEED);
  assign out_item_o       = out_q;

  `TDE_ASSERT_IMP(a_single_table_write, clk_i, rst_ni, !cmd_i.clear, !(type_we && trans_we))

endmodule

FILE: rtl/core/table_driven_dfa_engine_unit.sv
// Programmable table-driven DFA. After reset the block runs a clearing pass over
// the 16384 entries of the transition memory (one entry per cycle) and holds
// in_stall_o high until it is done. A fed symbol first reads the transition
// memory at the current state and symbol, then reads the type of the state
// reached, then hands over the result once the output is free. Every other
// operation reads the tables at accept and updates once the output is free.
// The result register lets the next item enter while a result is still stalled.
module table_driven_dfa_engine_unit import tde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tde_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_item_i (in_item_i),
    .status_o  (status),
    .out_item_o(out_item_o)
  );

endmodule
